>>> rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define BB3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define BB3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bb3_pkg.sv
// types, constants and helpers for the 3x3 box blur
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int PIX_W  = 24;
  localparam int CHAN_W = 8;
  localparam int CSUM_W = CHAN_W + 2;
  localparam int TSUM_W = CHAN_W + 4;

  localparam logic [DIM_W-1:0] DIM_MIN        = DIM_W'(3);
  localparam logic [DIM_W-1:0] DIM_MAX_WIDTH  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_HEIGHT = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] RESET_WIDTH    = DIM_W'(800);
  localparam logic [DIM_W-1:0] RESET_HEIGHT   = DIM_W'(600);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // ceil(2^16 / 9), exact for sums up to 9 * 255
  localparam int RECIP_SHIFT = 16;
  localparam logic [12:0] RECIP9 = 13'd7282;
  localparam int PROD_W = TSUM_W + 13;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CSUM_W-1:0] csum_t;
  typedef csum_t [2:0]       csum3_t;
  typedef logic [TSUM_W-1:0] tsum_t;
  typedef tsum_t [2:0]       tsum3_t;

  // per-item control carried from the input register to the window stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             row_ge1;
    logic             row_ge2;
    logic             inframe;
    logic             emit;
    logic             eof;
    pix_t             pix;
  } stage_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // channel sums of three pixels, blue in lane 0, red in lane 2
  function automatic csum3_t chan_sum3(input pix_t a, input pix_t b, input pix_t c);
    csum3_t s;
    for (int i = 0; i < 3; i++) begin
      s[i] = CSUM_W'(a[CHAN_W*i +: CHAN_W]) + CSUM_W'(b[CHAN_W*i +: CHAN_W])
           + CSUM_W'(c[CHAN_W*i +: CHAN_W]);
    end
    return s;
  endfunction

  function automatic logic [CHAN_W-1:0] div9(input tsum_t s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP9);
    return p[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

>>> rtl/bb3_line_buf.sv
// two line stores of the previous rows, registered read at the input column
module bb3_line_buf (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [bb3_pkg::COL_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [bb3_pkg::COL_W-1:0] wr_addr,
  input  bb3_pkg::pix_t             wr_upper,
  input  bb3_pkg::pix_t             wr_lower,
  output bb3_pkg::pix_t             upper_rd,
  output bb3_pkg::pix_t             lower_rd
);

  bb3_pkg::pix_t mem_upper [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pix_t mem_lower [bb3_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr] <= wr_upper;
    end
    if (rd_en) begin
      upper_rd <= mem_upper[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lower[wr_addr] <= wr_lower;
    end
    if (rd_en) begin
      lower_rd <= mem_lower[rd_addr];
    end
  end

endmodule

>>> rtl/bb3_ctrl.sv
// frame registers, raster counters and input register
module bb3_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,
  input  logic                      s_tuser,
  input  logic                      adv2,
  output logic                      v1,
  output bb3_pkg::stage_t           s1,
  output logic                      rd_en,
  output logic [bb3_pkg::COL_W-1:0] rd_addr
);

  logic [bb3_pkg::DIM_W-1:0] frame_width;
  logic [bb3_pkg::DIM_W-1:0] frame_height;
  logic [bb3_pkg::COL_W-1:0] in_column;
  logic [bb3_pkg::DIM_W-1:0] in_row;
  logic [bb3_pkg::COL_W-1:0] out_column;
  logic [bb3_pkg::ROW_W-1:0] out_row;

  logic [bb3_pkg::DIM_W-1:0] col_inc;
  logic [bb3_pkg::DIM_W-1:0] out_col_inc;
  logic [bb3_pkg::DIM_W-1:0] out_row_inc;
  logic                      inframe;
  logic                      emit;
  logic                      eof;
  logic                      load;
  bb3_pkg::stage_t           stage_in;

  always_comb begin
    col_inc     = bb3_pkg::DIM_W'(in_column) + 1'b1;
    out_col_inc = bb3_pkg::DIM_W'(out_column) + 1'b1;
    out_row_inc = bb3_pkg::DIM_W'(out_row) + 1'b1;
    inframe     = in_row < frame_height;
    emit        = (in_column == '0) ? (in_row >= bb3_pkg::DIM_W'(2))
                                    : (in_row >= bb3_pkg::DIM_W'(1));
    eof         = emit && (out_row_inc >= frame_height) && (out_col_inc >= frame_width);
    s_tready    = !v1 || adv2;
    // a flush while the frame still expects pixels is dropped here
    load        = s_tvalid && s_tready && !(inframe && s_tuser);
    rd_en       = load;
    rd_addr     = in_column;

    stage_in.col      = in_column;
    stage_in.col_zero = (in_column == '0);
    stage_in.row_ge1  = (in_row >= bb3_pkg::DIM_W'(1));
    stage_in.row_ge2  = (in_row >= bb3_pkg::DIM_W'(2));
    stage_in.inframe  = inframe;
    stage_in.emit     = emit;
    stage_in.eof      = eof;
    stage_in.pix      = inframe ? s_tdata[31:8] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::RESET_WIDTH;
      frame_height <= bb3_pkg::RESET_HEIGHT;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      v1           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bb3_pkg::REG_FRAME_WIDTH: begin
            frame_width <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::DIM_MAX_WIDTH);
          end
          bb3_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::DIM_MAX_HEIGHT);
          end
          default: begin
          end
        endcase
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else if (load) begin
        if (col_inc >= frame_width) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= col_inc[bb3_pkg::COL_W-1:0];
        end
        if (emit) begin
          if (eof) begin
            // last result of the frame: next item starts a new one
            in_column  <= '0;
            in_row     <= '0;
            out_column <= '0;
            out_row    <= '0;
          end else if (out_col_inc >= frame_width) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_col_inc[bb3_pkg::COL_W-1:0];
          end
        end
      end
      if (s_tready) begin
        v1 <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1 <= stage_in;
    end
  end

endmodule

>>> rtl/bb3_window.sv
// column sums of the 3x3 window and the registered neighborhood totals
module bb3_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      v1,
  input  bb3_pkg::stage_t           s1,
  input  bb3_pkg::pix_t             upper_rd,
  input  bb3_pkg::pix_t             lower_rd,
  input  logic                      adv3,
  output logic                      adv2,
  output logic                      v2,
  output bb3_pkg::tsum3_t           tot,
  output logic                      eof2,
  output logic                      wr_en,
  output logic [bb3_pkg::COL_W-1:0] wr_addr,
  output bb3_pkg::pix_t             wr_upper,
  output bb3_pkg::pix_t             wr_lower
);

  // older and newer column sums kept in the window
  bb3_pkg::csum3_t col_old;
  bb3_pkg::csum3_t col_new;

  bb3_pkg::pix_t   top;
  bb3_pkg::pix_t   mid;
  bb3_pkg::csum3_t in_sum;
  bb3_pkg::tsum3_t tot_next;

  always_comb begin
    top    = s1.row_ge2 ? upper_rd : '0;
    mid    = s1.row_ge1 ? lower_rd : '0;
    in_sum = bb3_pkg::chan_sum3(top, mid, s1.pix);
    for (int i = 0; i < 3; i++) begin
      // at column zero the right column is outside the frame
      tot_next[i] = bb3_pkg::TSUM_W'(col_old[i]) + bb3_pkg::TSUM_W'(col_new[i])
                  + (s1.col_zero ? '0 : bb3_pkg::TSUM_W'(in_sum[i]));
    end
    adv2     = !v2 || adv3;
    wr_en    = v1 && adv2 && s1.inframe;
    wr_addr  = s1.col;
    wr_upper = lower_rd;
    wr_lower = s1.pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      col_old <= '0;
      col_new <= '0;
    end else if (adv2) begin
      v2 <= v1 && s1.emit;
      if (v1) begin
        col_old <= s1.col_zero ? '0 : col_new;
        col_new <= in_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      tot  <= tot_next;
      eof2 <= s1.eof;
    end
  end

endmodule

>>> rtl/bb3_out.sv
// divide by nine, repack and hold the result item
module bb3_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            v2,
  input  bb3_pkg::tsum3_t tot,
  input  logic            eof2,
  input  logic            m_tready,
  output logic            adv3,
  output logic            m_tvalid,
  output logic [31:0]     m_tdata,
  output logic            m_tlast
);

  assign adv3 = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      m_tdata <= {bb3_pkg::div9(tot[2]), bb3_pkg::div9(tot[1]),
                  bb3_pkg::div9(tot[0]), bb3_pkg::ALPHA_OPAQUE};
      m_tlast <= eof2;
    end
  end

endmodule

>>> rtl/box_blur_3x3_rgb_top.sv
// 3x3 box blur over a raster stream of rgb pixels
//
//  channel  direction  tdata                 tuser / tlast
//  s_*      in         pixel_in [31:0]       tuser: flush
//  m_*      out        pixel_out [31:0]      tlast: end_of_frame
//  cfg_*    in         0 frame_width, 1 frame_height (11 bits, no read-back)
//
// one item per clock while s_tready is high; a result item passes the input register, window
// stage and output register, and it comes frame_width + 1 items after the pixel it belongs to
// the pace is set by the line stores, one read and one write port each
// reset clears the counters and window and loads 800 x 600; line stores are not cleared
// a stall on m_* fills the input register, window stage and output register before s_tready drops
module box_blur_3x3_rgb_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // pixel_in
  input  logic                      s_tuser,   // flush
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,   // pixel_out
  output logic                      m_tlast
);

  logic                      v1;
  bb3_pkg::stage_t           s1;
  logic                      rd_en;
  logic [bb3_pkg::COL_W-1:0] rd_addr;
  bb3_pkg::pix_t             upper_rd;
  bb3_pkg::pix_t             lower_rd;
  logic                      adv2;
  logic                      adv3;
  logic                      v2;
  bb3_pkg::tsum3_t           tot;
  logic                      eof2;
  logic                      wr_en;
  logic [bb3_pkg::COL_W-1:0] wr_addr;
  bb3_pkg::pix_t             wr_upper;
  bb3_pkg::pix_t             wr_lower;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .adv2      (adv2),
    .v1        (v1),
    .s1        (s1),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  bb3_line_buf u_line_buf (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_upper (wr_upper),
    .wr_lower (wr_lower),
    .upper_rd (upper_rd),
    .lower_rd (lower_rd)
  );

  bb3_window u_window (
    .clk      (clk),
    .rst      (rst),
    .v1       (v1),
    .s1       (s1),
    .upper_rd (upper_rd),
    .lower_rd (lower_rd),
    .adv3     (adv3),
    .adv2     (adv2),
    .v2       (v2),
    .tot      (tot),
    .eof2     (eof2),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_upper (wr_upper),
    .wr_lower (wr_lower)
  );

  bb3_out u_out (
    .clk      (clk),
    .rst      (rst),
    .v2       (v2),
    .tot      (tot),
    .eof2     (eof2),
    .m_tready (m_tready),
    .adv3     (adv3),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/bb3_checker.sv
// port checker for the box blur top level, bound to it
`include "assert_macros.svh"

module bb3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // a waiting result item holds its value
  `BB3_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result item changed while stalled")

  `BB3_ASSERT(a_alpha, m_tvalid |-> m_tdata[7:0] == 8'hFF, "alpha byte of result is not opaque")

  // with the output register empty the whole pipe can move
  `BB3_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output register")

  `BB3_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result item shown right after reset")

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> bench/tb_box_blur_3x3_rgb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the 3x3 rgb box blur stream
module tb_box_blur_3x3_rgb_top;

  localparam int ITEM_TARGET   = 1100;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int MIN_DIM       = 3;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } blurred_t;

  // one window column, oldest row in lane 0
  typedef bb3_pkg::pix_t [2:0] column_t;

  typedef enum logic {DO_ITEM, DO_WRITE} step_kind_e;
  typedef enum logic [1:0] {FROM_MODEL, NO_RESULT, FIXED} check_e;

  typedef struct packed {
    step_kind_e                kind;
    logic                      index;
    logic [bb3_pkg::DIM_W-1:0] value;
    logic                      flush;
    logic [31:0]               pixel;
    check_e                    check;
    blurred_t                  want;
  } step_t;

  // averages of an all-white frame: 4, 6 or 9 neighbours inside
  localparam blurred_t NO_BLUR    = '0;
  localparam blurred_t CORNER_AVG = '{32'h717171FF, 1'b0};
  localparam blurred_t SIDE_AVG   = '{32'hAAAAAAFF, 1'b0};
  localparam blurred_t CENTER_AVG = '{32'hFFFFFFFF, 1'b0};
  localparam blurred_t LAST_AVG   = '{32'h717171FF, 1'b1};

  step_t directed_steps [20] = '{
    // 800 x 600 after reset: nothing leaves this early
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFFFF, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'hFFFFFFFF, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'h00000000, NO_RESULT, NO_BLUR},
    // sizes below the floor clamp to 3
    '{DO_WRITE, bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'h0,        NO_RESULT, NO_BLUR},
    '{DO_WRITE, bb3_pkg::REG_FRAME_HEIGHT, 11'd2, 1'b0, 32'h0,        NO_RESULT, NO_BLUR},
    // white 3x3 frame, alpha varies and must not matter
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFF00, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFFFF, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'h00000000, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFF00, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFFFF, NO_RESULT, NO_BLUR},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFF00, FIXED,     CORNER_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFFFF, FIXED,     SIDE_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFF00, FIXED,     CORNER_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFFFF, FIXED,     SIDE_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'hFFFFFF00, FIXED,     CENTER_AVG},
    // drain; a pixel past the frame acts as a flush
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b0, 32'h12345678, FIXED,     SIDE_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'h0,        FIXED,     CORNER_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'h0,        FIXED,     SIDE_AVG},
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'h0,        FIXED,     LAST_AVG},
    // a new frame has begun, so this flush is dropped
    '{DO_ITEM,  bb3_pkg::REG_FRAME_WIDTH,  11'd0, 1'b1, 32'h0,        NO_RESULT, NO_BLUR}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = 1'b0;
  logic [bb3_pkg::DIM_W-1:0] cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [31:0]               s_tdata = '0;   // pixel_in
  logic                      s_tuser = 1'b0; // flush
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [31:0]               m_tdata;        // pixel_out
  logic                      m_tlast;        // end_of_frame

  blurred_t pending_blurs [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int item_count = 0;
  bit tx_calm = 1'b0;

  // blur state mirror
  bb3_pkg::pix_t upper_row [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pix_t lower_row [bb3_pkg::MAX_WIDTH];
  column_t       window [3];
  int unsigned   frame_w, frame_h;
  int unsigned   in_col, in_row, out_col, out_row;

  box_blur_3x3_rgb_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reset_frame_state();
    for (int i = 0; i < 3; i++) window[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  function automatic int unsigned fit_dim(input logic [bb3_pkg::DIM_W-1:0] v,
                                          input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic apply_write(input logic idx, input logic [bb3_pkg::DIM_W-1:0] v);
    if (idx == bb3_pkg::REG_FRAME_WIDTH) begin
      frame_w = fit_dim(v, bb3_pkg::MAX_WIDTH);
    end else begin
      frame_h = fit_dim(v, bb3_pkg::MAX_HEIGHT);
    end
    reset_frame_state();
  endtask

  function automatic logic [31:0] average9(input column_t a, input column_t b,
                                           input column_t c);
    int unsigned red = 0;
    int unsigned green = 0;
    int unsigned blue = 0;
    column_t cols [3];
    bb3_pkg::pix_t p;
    cols[0] = a;
    cols[1] = b;
    cols[2] = c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = cols[i][j];
        red += 32'(p[23:16]);
        green += 32'(p[15:8]);
        blue += 32'(p[7:0]);
      end
    end
    return {8'(red / 9), 8'(green / 9), 8'(blue / 9), bb3_pkg::ALPHA_OPAQUE};
  endfunction

  // one accepted item through the blur; says whether a pixel leaves and which
  task automatic predict_blur(input logic fl, input logic [31:0] px,
                              output bit emitted, output blurred_t res);
    int unsigned c;
    int unsigned r;
    bit inframe;
    bb3_pkg::pix_t pix;
    column_t fresh;
    c = in_col;
    r = in_row;
    inframe = (r < frame_h);
    emitted = 1'b0;
    res = '0;
    // a flush inside the frame is dropped without a trace
    if (!(inframe && fl)) begin
      pix = inframe ? px[31:8] : '0;
      fresh[0] = (r >= 2) ? upper_row[c] : '0;
      fresh[1] = (r >= 1) ? lower_row[c] : '0;
      fresh[2] = pix;
      if (inframe) begin
        upper_row[c] = lower_row[c];
        lower_row[c] = pix;
      end
      if (c == 0) begin
        // right neighbour of the last column lies outside the frame
        if (r >= 2) begin
          res.pixel = average9(window[1], window[2], '0);
          emitted = 1'b1;
        end
        window[0] = '0;
        window[1] = '0;
        window[2] = fresh;
      end else begin
        window[0] = window[1];
        window[1] = window[2];
        window[2] = fresh;
        if (r >= 1) begin
          res.pixel = average9(window[0], window[1], window[2]);
          emitted = 1'b1;
        end
      end
      c++;
      if (c >= frame_w) begin
        c = 0;
        r++;
      end
      in_col = c;
      in_row = r;
      if (emitted) begin
        if (out_row + 1 >= frame_h && out_col + 1 >= frame_w) begin
          res.last = 1'b1;
          reset_frame_state();
        end else begin
          out_col++;
          if (out_col >= frame_w) begin
            out_col = 0;
            out_row++;
          end
        end
      end
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [31:0] random_pixel();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'h0;
    if (roll == 1) return 32'hFFFFFFFF;
    return $urandom;
  endfunction

  function automatic logic [bb3_pkg::DIM_W-1:0] pick_small_dim(input int common_hi,
                                                               input int rare_hi);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return bb3_pkg::DIM_W'($urandom_range(0, MIN_DIM - 1));
    if (roll < 17) return bb3_pkg::DIM_W'($urandom_range(MIN_DIM, common_hi));
    return bb3_pkg::DIM_W'($urandom_range(common_hi + 1, rare_hi));
  endfunction

  // valid stays high across back-to-back items; lowered here only for a gap
  task automatic offer_item(input logic fl, input logic [31:0] px, input check_e chk,
                            input blurred_t want);
    int gap;
    bit emitted;
    blurred_t predicted;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= fl;
    do @(posedge clk); while (s_tready !== 1'b1);
    item_count++;
    predict_blur(fl, px, emitted, predicted);
    if (chk == FIXED) begin
      pending_blurs.push_back(want);
    end else if (chk == FROM_MODEL && emitted) begin
      pending_blurs.push_back(predicted);
    end
  endtask

  task automatic wait_block_idle(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_blurs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [bb3_pkg::DIM_W-1:0] v);
    wait_block_idle(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, v);
  endtask

  task automatic small_dims();
    write_register(bb3_pkg::REG_FRAME_WIDTH, pick_small_dim(8, 40));
    write_register(bb3_pkg::REG_FRAME_HEIGHT, pick_small_dim(6, 12));
  endtask

  // a frame cut short by the next write, with stray flushes
  task automatic run_partial(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_item(1'b1, $urandom, FROM_MODEL, NO_BLUR);
      end else begin
        offer_item(1'b0, random_pixel(), FROM_MODEL, NO_BLUR);
      end
    end
  endtask

  // whole frames with random content, stray flushes and a mixed drain
  task automatic run_frames(input int frames);
    int total;
    int pause_at;
    for (int f = 0; f < frames; f++) begin
      total = int'(frame_w * frame_h);
      pause_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, total - 1)) : -1;
      for (int k = 0; k < total; k++) begin
        if (k == pause_at) wait_block_idle(0);
        if ($urandom_range(0, 19) == 0) offer_item(1'b1, $urandom, FROM_MODEL, NO_BLUR);
        offer_item(1'b0, random_pixel(), FROM_MODEL, NO_BLUR);
      end
      for (int k = 0; k <= frame_w; k++) begin
        offer_item($urandom_range(0, 3) != 0, random_pixel(), FROM_MODEL, NO_BLUR);
      end
      if ($urandom_range(0, 3) == 0) offer_item(1'b1, $urandom, FROM_MODEL, NO_BLUR);
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int next_hold;
    int calm_left;
    int results_seen;
    bit rx_calm;
    blurred_t want;
    stall_left = 0;
    next_hold = 40;
    calm_left = 0;
    results_seen = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (pending_blurs.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item: expected none, got pixel_out %08h end_of_frame %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = pending_blurs.pop_front();
          if (m_tdata !== want.pixel) begin
            mismatch_count++;
            $display("%0t: pixel_out mismatch: expected %08h, got %08h",
                     $time, want.pixel, m_tdata);
          end
          if (m_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: end_of_frame mismatch: expected %0b, got %0b",
                     $time, want.last, m_tlast);
          end
        end
        // long hold-off so the pipeline backs up into s_tready
        if (results_seen == next_hold) begin
          stall_left = LONG_HOLD;
          next_hold += 700;
        end
      end
      if (calm_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 400);
      end else begin
        calm_left--;
      end
      if (stall_left == 0 && !rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(1'b0);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    step_t st;
    logic [1:0] wsel;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    frame_w = 32'(bb3_pkg::RESET_WIDTH);
    frame_h = 32'(bb3_pkg::RESET_HEIGHT);
    reset_frame_state();

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.kind == DO_WRITE) begin
        write_register(st.index, st.value);
      end else begin
        offer_item(st.flush, st.pixel, st.check, st.want);
      end
    end

    for (int phase = 0; phase <= 5 || item_count < ITEM_TARGET; phase++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // widest row; all-ones write clamps to the maximum
        write_register(bb3_pkg::REG_FRAME_WIDTH, 11'h7FF);
        write_register(bb3_pkg::REG_FRAME_HEIGHT, 11'd3);
        run_partial(60);
        small_dims();
      end else if (phase == 5) begin
        // width clamps up to 3 against the tallest frame
        write_register(bb3_pkg::REG_FRAME_WIDTH, 11'd1);
        write_register(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::DIM_W'(bb3_pkg::MAX_HEIGHT));
        run_partial(80);
        small_dims();
      end else if ($urandom_range(0, 5) == 0) begin
        // any 11-bit sizes, frame cut short by the next write
        write_register(bb3_pkg::REG_FRAME_WIDTH, bb3_pkg::DIM_W'($urandom));
        write_register(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::DIM_W'($urandom));
        run_partial($urandom_range(1, 60));
        small_dims();
      end else begin
        wsel = 2'($urandom_range(1, 3));
        if (wsel[0]) write_register(bb3_pkg::REG_FRAME_WIDTH, pick_small_dim(8, 40));
        if (wsel[1]) write_register(bb3_pkg::REG_FRAME_HEIGHT, pick_small_dim(6, 12));
        run_frames($urandom_range(1, 3));
      end
    end

    wait_block_idle(4 * SETTLE_CYCLES);
    if (mismatch_count == 0 && pending_blurs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
